// ===== sv/bernstein_poly_eval_unit_assert.svh =====
// Assertion macros used by the Bernstein evaluator RTL.
// Depends on a clk and an active-low rst_n in the including module.
`ifndef BERNSTEIN_POLY_EVAL_UNIT_ASSERT_SVH
`define BERNSTEIN_POLY_EVAL_UNIT_ASSERT_SVH

// same-cycle implication
`define BPE_ASSERT_NOW(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication
`define BPE_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ===== sv/bpe_pkg.sv =====
`timescale 1ns / 1ps
// Shared types and constants for the Bernstein polynomial evaluator.
// No dependencies.
package bpe_pkg;

  localparam int MAX_DEGREE_DEF = 16;
  localparam int DEG_W          = 5;
  localparam int IDX_W          = 5;
  localparam int COEF_W         = 32;
  localparam int PT_W           = 17;
  localparam int PROD_W         = COEF_W + PT_W + 1;
  localparam int ONE_Q16        = 65536;
  localparam int ROUND_HALF     = 32768;
  localparam int IN_TDATA_W     = 56;
  localparam int OUT_TDATA_W    = 56;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_PRIME_RD,
    ST_PRIME_LD,
    ST_MUL_A,
    ST_MUL_B,
    ST_ACC
  } state_t;

  // controller -> datapath
  typedef struct packed {
    logic coef_wr;     // load transfer
    logic take_point;  // evaluate transfer
    logic src_coef;    // read data comes from the coefficient store
    logic prime_ld;    // prev <= b0 of the first level
    logic mul_a;       // prod_a <= S * prev
    logic mul_b;       // prod_b <= X * next, cur <= next
    logic acc;         // round, write back b_j
    logic lvl_end;     // last step of a level
    logic out_load;    // final value to the output register
  } cmd_t;

  // datapath -> controller
  typedef struct packed {
    logic out_busy;
  } status_t;

endpackage

// ===== sv/bpe_dp.sv =====
`timescale 1ns / 1ps
// Datapath: coefficient store, work store, shared multiplier, output register.
// Depends on bpe_pkg; driven by bpe_ctrl.
module bpe_dp #(
  parameter int MaxDegree = bpe_pkg::MAX_DEGREE_DEF,
  parameter int AddrW     = $clog2(MaxDegree + 1)
) (
  input  logic                          clk,
  input  logic                          rst_n,
  input  bpe_pkg::cmd_t                 cmd,
  input  logic [AddrW-1:0]              rd_addr,
  input  logic [AddrW-1:0]              wr_addr,
  output bpe_pkg::status_t              st,
  input  logic [bpe_pkg::IDX_W-1:0]     in_coef_index,
  input  logic signed [bpe_pkg::COEF_W-1:0] in_coef_value,
  input  logic [bpe_pkg::PT_W-1:0]      in_point,
  output logic                          out_valid,
  input  logic                          out_ready,
  output logic signed [bpe_pkg::COEF_W-1:0] out_value,
  output logic [bpe_pkg::PT_W-1:0]      out_point_echo
);
  import bpe_pkg::*;

  localparam int Depth = MaxDegree + 1;

  logic signed [COEF_W-1:0] coef_mem [Depth];
  logic signed [COEF_W-1:0] work_mem [Depth];
  logic signed [COEF_W-1:0] coef_q_r, work_q_r, rd_q;
  logic signed [COEF_W-1:0] prev_r, cur_r, first_r, new_b;
  logic [PT_W-1:0]          x_r, s_r, pt_sat, mul_k;
  logic signed [COEF_W-1:0] mul_op;
  logic signed [PT_W:0]     mul_k_s;
  logic signed [PROD_W-1:0] prod, prod_a_r, prod_b_r;
  logic signed [PROD_W:0]   sum_w;
  logic                     idx_ok;
  logic                     out_valid_r;
  logic signed [COEF_W-1:0] out_value_r;
  logic [PT_W-1:0]          out_point_r;

  assign idx_ok = (7'(in_coef_index) <= 7'(MaxDegree));
  assign pt_sat = (in_point > PT_W'(ONE_Q16)) ? PT_W'(ONE_Q16) : in_point;

  always_ff @(posedge clk) begin
    if (cmd.coef_wr && idx_ok) begin
      coef_mem[AddrW'(in_coef_index)] <= in_coef_value;
    end
    coef_q_r <= coef_mem[rd_addr];
  end

  always_ff @(posedge clk) begin
    if (cmd.acc) begin
      work_mem[wr_addr] <= new_b;
    end
    work_q_r <= work_mem[rd_addr];
  end

  assign rd_q = cmd.src_coef ? coef_q_r : work_q_r;

  // one shared 18x32 signed multiplier
  assign mul_k   = cmd.mul_a ? s_r : x_r;
  assign mul_op  = cmd.mul_a ? prev_r : rd_q;
  assign mul_k_s = signed'({1'b0, mul_k});
  assign prod    = PROD_W'(mul_k_s) * PROD_W'(mul_op);

  // round half up; convex combination keeps the result in 32 bits
  assign sum_w = (PROD_W+1)'(prod_a_r) + (PROD_W+1)'(prod_b_r) + (PROD_W+1)'(ROUND_HALF);
  assign new_b = sum_w[COEF_W+15:16];

  always_ff @(posedge clk) begin
    if (cmd.take_point) begin
      x_r <= pt_sat;
      s_r <= PT_W'(ONE_Q16) - pt_sat;
    end
    if (cmd.mul_a) begin
      prod_a_r <= prod;
    end
    if (cmd.mul_b) begin
      prod_b_r <= prod;
      cur_r    <= rd_q;
    end
    if (cmd.acc && wr_addr == '0) begin
      first_r <= new_b;
    end
    if (cmd.prime_ld) begin
      prev_r <= rd_q;
    end else if (cmd.acc) begin
      if (!cmd.lvl_end) begin
        prev_r <= cur_r;
      end else if (wr_addr == '0) begin
        prev_r <= new_b;
      end else begin
        prev_r <= first_r;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (cmd.out_load) begin
      out_valid_r <= 1'b1;
    end else if (out_ready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.out_load) begin
      out_value_r <= new_b;
      out_point_r <= x_r;
    end
  end

  assign st.out_busy    = out_valid_r && !out_ready;
  assign out_valid      = out_valid_r;
  assign out_value      = out_value_r;
  assign out_point_echo = out_point_r;

endmodule

// ===== sv/bpe_ctrl.sv =====
`timescale 1ns / 1ps
// Controller: degree register, level/step counters and the step sequencer.
// Depends on bpe_pkg and the assertion macro header.
`include "bernstein_poly_eval_unit_assert.svh"
module bpe_ctrl #(
  parameter int MaxDegree = bpe_pkg::MAX_DEGREE_DEF,
  parameter int AddrW     = $clog2(MaxDegree + 1)
) (
  input  logic                      clk,
  input  logic                      rst_n,
  input  logic                      cfg_wr_en,
  input  logic [bpe_pkg::DEG_W-1:0] cfg_wr_data,
  input  logic                      in_valid,
  input  logic                      in_kind,
  output logic                      in_ready,
  input  bpe_pkg::status_t          st,
  output bpe_pkg::cmd_t             cmd,
  output logic [AddrW-1:0]          rd_addr,
  output logic [AddrW-1:0]          wr_addr
);
  import bpe_pkg::*;

  state_t           state_r, state_nxt;
  logic [DEG_W-1:0] degree_r;
  logic [AddrW-1:0] lvl_r, lvl_nxt, j_r, j_nxt, n_eff;
  logic             src_coef_r, src_coef_nxt;
  logic             accept, eval_go, last_step, final_step;

  assign accept     = in_valid && in_ready;
  assign eval_go    = accept && in_kind;
  assign last_step  = (j_r == lvl_r - AddrW'(1));
  assign final_step = last_step && (lvl_r == AddrW'(1));

  always_comb begin
    if (degree_r == '0) begin
      n_eff = AddrW'(1);
    end else if (7'(degree_r) > 7'(MaxDegree)) begin
      n_eff = AddrW'(MaxDegree);
    end else begin
      n_eff = AddrW'(degree_r);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r    <= ST_IDLE;
      degree_r   <= DEG_W'(1);
      lvl_r      <= '0;
      j_r        <= '0;
      src_coef_r <= 1'b0;
    end else begin
      state_r    <= state_nxt;
      lvl_r      <= lvl_nxt;
      j_r        <= j_nxt;
      src_coef_r <= src_coef_nxt;
      if (cfg_wr_en) begin
        degree_r <= cfg_wr_data;
      end
    end
  end

  // next state
  always_comb begin
    state_nxt = state_r;
    case (state_r)
      ST_IDLE:     if (eval_go) state_nxt = ST_PRIME_RD;
      ST_PRIME_RD: state_nxt = ST_PRIME_LD;
      ST_PRIME_LD: state_nxt = ST_MUL_A;
      ST_MUL_A:    state_nxt = ST_MUL_B;
      ST_MUL_B:    state_nxt = ST_ACC;
      ST_ACC: begin
        if (!final_step) begin
          state_nxt = ST_MUL_A;
        end else if (!st.out_busy) begin
          state_nxt = ST_IDLE;
        end
      end
      default:     state_nxt = ST_IDLE;
    endcase
  end

  // level and step counters
  always_comb begin
    lvl_nxt      = lvl_r;
    j_nxt        = j_r;
    src_coef_nxt = src_coef_r;
    if (state_r == ST_IDLE && eval_go) begin
      lvl_nxt      = n_eff;
      j_nxt        = '0;
      src_coef_nxt = 1'b1;
    end else if (state_r == ST_ACC && !final_step) begin
      if (last_step) begin
        lvl_nxt      = lvl_r - AddrW'(1);
        j_nxt        = '0;
        src_coef_nxt = 1'b0;
      end else begin
        j_nxt = j_r + AddrW'(1);
      end
    end
  end

  // outputs
  always_comb begin
    cmd          = '0;
    cmd.src_coef = src_coef_r;
    in_ready     = 1'b0;
    rd_addr      = j_r + AddrW'(1);
    wr_addr      = j_r;
    case (state_r)
      ST_IDLE: begin
        in_ready       = 1'b1;
        cmd.coef_wr    = accept && !in_kind;
        cmd.take_point = eval_go;
      end
      ST_PRIME_RD: rd_addr = '0;
      ST_PRIME_LD: cmd.prime_ld = 1'b1;
      ST_MUL_A:    cmd.mul_a = 1'b1;
      ST_MUL_B:    cmd.mul_b = 1'b1;
      ST_ACC: begin
        cmd.acc      = 1'b1;
        cmd.lvl_end  = last_step;
        cmd.out_load = final_step && !st.out_busy;
      end
      default: ;
    endcase
  end

  `BPE_ASSERT_NOW(a_no_overwrite, cmd.out_load, !st.out_busy, "result overwritten")
  `BPE_ASSERT_NEXT(a_eval_start, eval_go, state_r == ST_PRIME_RD, "evaluate did not start")
  `BPE_ASSERT_NEXT(a_step_adv, state_r == ST_ACC && !last_step,
                   state_r == ST_MUL_A && j_r == $past(j_r) + AddrW'(1), "step skipped")
  `BPE_ASSERT_NOW(a_lvl_live, state_r != ST_IDLE && state_r != ST_PRIME_RD,
                  lvl_r != '0 && j_r < lvl_r, "counter out of range")

endmodule

// ===== sv/bernstein_poly_eval_unit.sv =====
`timescale 1ns / 1ps
// Channel  Dir  Payload
// in_      in   tuser: kind; tdata: coef_index, coef_value, point
// out_     out  tdata: value, point_echo
// cfg_     in   wr_data: degree
//
// An evaluate transfer primes b0 (ST_PRIME_RD, ST_PRIME_LD) and then runs the
// de Casteljau steps one at a time through one shared multiplier, each step in
// ST_MUL_A, ST_MUL_B and ST_ACC, until the result is in the output register.
// rst_n is synchronous and clears control state and degree (to 1); coefficients
// are undefined until loaded. A stalled result holds the block at its final
// step; a new item is taken while a result waits.
// Top level: joins bpe_ctrl and bpe_dp; depends on bpe_pkg.
module bernstein_poly_eval_unit #(
  parameter int MaxDegree = bpe_pkg::MAX_DEGREE_DEF
) (
  input  logic                            clk,
  input  logic                            rst_n,
  input  logic                            cfg_wr_en,
  input  logic [bpe_pkg::DEG_W-1:0]       cfg_wr_data,   // degree
  input  logic                            in_tvalid,
  output logic                            in_tready,
  input  logic [bpe_pkg::IN_TDATA_W-1:0]  in_tdata,      // coef_index, coef_value, point
  input  logic                            in_tuser,      // kind
  output logic                            out_tvalid,
  input  logic                            out_tready,
  output logic [bpe_pkg::OUT_TDATA_W-1:0] out_tdata      // value, point_echo
);
  import bpe_pkg::*;

  localparam int AddrW = $clog2(MaxDegree + 1);

  cmd_t                     cmd;
  status_t                  st;
  logic [AddrW-1:0]         rd_addr, wr_addr;
  logic signed [COEF_W-1:0] value;
  logic [PT_W-1:0]          point_echo;

  bpe_ctrl #(.MaxDegree(MaxDegree), .AddrW(AddrW)) u_ctrl (
    .clk        (clk),
    .rst_n      (rst_n),
    .cfg_wr_en  (cfg_wr_en),
    .cfg_wr_data(cfg_wr_data),
    .in_valid   (in_tvalid),
    .in_kind    (in_tuser),
    .in_ready   (in_tready),
    .st         (st),
    .cmd        (cmd),
    .rd_addr    (rd_addr),
    .wr_addr    (wr_addr)
  );

  bpe_dp #(.MaxDegree(MaxDegree), .AddrW(AddrW)) u_dp (
    .clk           (clk),
    .rst_n         (rst_n),
    .cmd           (cmd),
    .rd_addr       (rd_addr),
    .wr_addr       (wr_addr),
    .st            (st),
    .in_coef_index (in_tdata[4:0]),
    .in_coef_value (signed'(in_tdata[36:5])),
    .in_point      (in_tdata[53:37]),
    .out_valid     (out_tvalid),
    .out_ready     (out_tready),
    .out_value     (value),
    .out_point_echo(point_echo)
  );

  assign out_tdata = {7'b0, point_echo, value};

endmodule

// ===== tb/bpe_eval_checker.sv =====
`timescale 1ns / 1ps
// Testbench-side package and scoreboard for the Bernstein polynomial evaluator.
// Depends on bpe_pkg; the scoreboard predicts every evaluate transfer with de Casteljau.
package bpe_tb_pkg;
  import bpe_pkg::*;

  localparam logic KIND_LOAD = 1'b0;
  localparam logic KIND_EVAL = 1'b1;

  // in_tdata fields, lowest first
  localparam int IDX_LSB = 0;
  localparam int VAL_LSB = IDX_W;
  localparam int PT_LSB  = IDX_W + COEF_W;

  // out_tdata fields, lowest first
  localparam int OUT_VAL_LSB = 0;
  localparam int OUT_PT_LSB  = COEF_W;
endpackage

module bpe_eval_checker
  import bpe_pkg::*;
  import bpe_tb_pkg::*;
(
  input  logic                   clk,
  input  logic                   rst_n,
  input  logic                   cfg_wr_en,
  input  logic [DEG_W-1:0]       cfg_wr_data,
  input  logic                   in_tvalid,
  input  logic                   in_tready,
  input  logic [IN_TDATA_W-1:0]  in_tdata,
  input  logic                   in_tuser,
  input  logic                   out_tvalid,
  input  logic                   out_tready,
  input  logic [OUT_TDATA_W-1:0] out_tdata,
  output int                     mismatches,
  output int                     evals_pending
);

  typedef struct packed {
    logic [COEF_W-1:0] value;
    logic [PT_W-1:0]   point;
  } eval_result_t;

  eval_result_t             expected_evals[$];
  logic signed [COEF_W-1:0] coef_store[MAX_DEGREE_DEF+1];
  logic [DEG_W-1:0]         degree = DEG_W'(1);

  // pt is already saturated to 1.0
  function automatic logic [COEF_W-1:0] casteljau_value(input logic [PT_W-1:0] pt);
    longint b[MAX_DEGREE_DEF+1];
    longint x_q;
    longint s_q;
    int     n;
    n = degree;
    if (n < 1) n = 1;
    if (n > MAX_DEGREE_DEF) n = MAX_DEGREE_DEF;
    x_q = pt;
    s_q = ONE_Q16 - x_q;
    for (int j = 0; j <= n; j++) b[j] = coef_store[j];
    // round half up == arithmetic shift of the biased sum
    for (int lvl = n; lvl > 0; lvl--)
      for (int j = 0; j < lvl; j++)
        b[j] = (s_q * b[j] + x_q * b[j+1] + ROUND_HALF) >>> 16;
    return COEF_W'(b[0]);
  endfunction

  task automatic flag_mismatch(input string msg);
    mismatches++;
    if (mismatches <= 10) $display("%0t: %s", $realtime, msg);
  endtask

  always @(posedge clk) begin : scoreboard
    logic [PT_W-1:0]   pt;
    logic [IDX_W-1:0]  idx;
    eval_result_t      got;
    eval_result_t      want;
    if (!rst_n) begin
      degree = DEG_W'(1);
      expected_evals.delete();
    end else begin
      // retire before accepting so a same-edge evaluate cannot match a stray result
      if (out_tvalid && out_tready) begin
        got.value = out_tdata[OUT_VAL_LSB +: COEF_W];
        got.point = out_tdata[OUT_PT_LSB +: PT_W];
        if (expected_evals.size() == 0) begin
          flag_mismatch($sformatf("unexpected result value=%0d point=%0d",
                                  $signed(got.value), got.point));
        end else begin
          want = expected_evals.pop_front();
          if (got.value != want.value)
            flag_mismatch($sformatf("value mismatch at point %0d: exp %0d got %0d",
                                    want.point, $signed(want.value), $signed(got.value)));
          if (got.point != want.point)
            flag_mismatch($sformatf("point_echo mismatch: exp %0d got %0d",
                                    want.point, got.point));
        end
      end
      if (in_tvalid && in_tready) begin
        if (in_tuser == KIND_LOAD) begin
          idx = in_tdata[IDX_LSB +: IDX_W];
          if (idx <= MAX_DEGREE_DEF) coef_store[idx] = in_tdata[VAL_LSB +: COEF_W];
        end else begin
          pt = in_tdata[PT_LSB +: PT_W];
          if (pt > ONE_Q16) pt = PT_W'(ONE_Q16);
          want.value = casteljau_value(pt);
          want.point = pt;
          expected_evals.push_back(want);
        end
      end
      if (cfg_wr_en) degree = cfg_wr_data;
    end
    evals_pending <= expected_evals.size();
  end

endmodule

// ===== tb/tb_bernstein_poly_eval_unit.sv =====
`timescale 1ns / 1ps
// Top of the Bernstein evaluator testbench: clock, reset, stimulus and verdict.
// Depends on bpe_pkg, bpe_tb_pkg/bpe_eval_checker and bernstein_poly_eval_unit.
module tb_bernstein_poly_eval_unit;
  import bpe_pkg::*;
  import bpe_tb_pkg::*;

  // longest evaluate (n = 16) plus margin
  localparam int DRAIN_CYCLES = 3 * MAX_DEGREE_DEF * (MAX_DEGREE_DEF + 1) / 2 + 40;

  logic                   clk = 1'b0;
  logic                   rst_n = 1'b0;
  logic                   cfg_wr_en = 1'b0;
  logic [DEG_W-1:0]       cfg_wr_data = '0;
  logic                   in_tvalid = 1'b0;
  logic                   in_tready;
  logic [IN_TDATA_W-1:0]  in_tdata = '0;
  logic                   in_tuser = 1'b0;
  logic                   out_tvalid;
  logic                   out_tready = 1'b0;
  logic [OUT_TDATA_W-1:0] out_tdata;

  int mismatches;
  int evals_pending;
  int src_idle_pct  = 35;
  int sink_idle_pct = 66;
  int items_sent    = 0;

  // degrees of the random phases; 0 and above MAX_DEGREE hit the clamping
  int phase_deg[15] = '{16, 0, 1, 31, 2, 3, 5, 7, 16, 4, 1, 17, 10, 2, 8};

  bernstein_poly_eval_unit u_top (
    .clk        (clk),
    .rst_n      (rst_n),
    .cfg_wr_en  (cfg_wr_en),
    .cfg_wr_data(cfg_wr_data),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .in_tuser   (in_tuser),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata)
  );

  bpe_eval_checker u_checker (
    .clk          (clk),
    .rst_n        (rst_n),
    .cfg_wr_en    (cfg_wr_en),
    .cfg_wr_data  (cfg_wr_data),
    .in_tvalid    (in_tvalid),
    .in_tready    (in_tready),
    .in_tdata     (in_tdata),
    .in_tuser     (in_tuser),
    .out_tvalid   (out_tvalid),
    .out_tready   (out_tready),
    .out_tdata    (out_tdata),
    .mismatches   (mismatches),
    .evals_pending(evals_pending)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  always @(posedge clk) begin
    out_tready <= ($urandom_range(99) >= sink_idle_pct);
  end

  task automatic push_item(input logic kind, input logic [IDX_W-1:0] idx,
                           input logic [COEF_W-1:0] val, input logic [PT_W-1:0] pt);
    while ($urandom_range(99) < src_idle_pct) begin
      in_tvalid <= 1'b0;
      @(posedge clk);
    end
    in_tvalid <= 1'b1;
    in_tuser  <= kind;
    in_tdata  <= {{(IN_TDATA_W - PT_LSB - PT_W){1'b0}}, pt, val, idx};
    do @(posedge clk); while (!in_tready);
    items_sent++;
    if (items_sent == 570) begin
      src_idle_pct  = 66;
      sink_idle_pct = 35;
    end else if (items_sent == 1140) begin
      src_idle_pct  = 0;
      sink_idle_pct = 0;
    end
  endtask

  // the pending count is registered and lags the scoreboard, so look past the last transfer
  task automatic wait_drained();
    in_tvalid <= 1'b0;
    do @(posedge clk); while (evals_pending != 0);
    repeat (DRAIN_CYCLES) @(posedge clk);
  endtask

  task automatic write_degree(input logic [DEG_W-1:0] d);
    cfg_wr_en   <= 1'b1;
    cfg_wr_data <= d;
    @(posedge clk);
    cfg_wr_en   <= 1'b0;
  endtask

  task automatic random_item();
    logic [IDX_W-1:0]  idx;
    logic [COEF_W-1:0] val;
    logic [PT_W-1:0]   pt;
    int                r;
    // unused fields carry noise
    idx = IDX_W'($urandom);
    val = $urandom;
    pt  = PT_W'($urandom);
    if ($urandom_range(99) < 45) begin
      if ($urandom_range(99) < 85) idx = IDX_W'($urandom_range(MAX_DEGREE_DEF));
      else idx = IDX_W'($urandom_range(2**IDX_W - 1, MAX_DEGREE_DEF + 1));
      case ($urandom_range(9))
        0: val = 32'h7FFF_FFFF;
        1: val = 32'h8000_0000;
        2: val = '0;
        3: val = '1;
        default: ;
      endcase
      push_item(KIND_LOAD, idx, val, pt);
    end else begin
      r = $urandom_range(9);
      if (r == 0) pt = '0;
      else if (r == 1) pt = PT_W'(ONE_Q16);
      else if (r == 2) pt = PT_W'($urandom_range(2**PT_W - 1, ONE_Q16 + 1));
      else pt = PT_W'($urandom_range(ONE_Q16 - 1));
      push_item(KIND_EVAL, idx, val, pt);
    end
  endtask

  initial begin : stimulus
    logic [COEF_W-1:0] v;
    int                n_items;
    repeat (7) @(posedge clk);
    rst_n <= 1'b1;

    // fill every coefficient with alternating extremes before any evaluate
    for (int k = 0; k <= MAX_DEGREE_DEF; k++) begin
      v = k[0] ? 32'h8000_0000 + k : 32'h7FFF_FFFF - k;
      push_item(KIND_LOAD, IDX_W'(k), v, PT_W'($urandom));
    end
    // out-of-range loads are dropped
    push_item(KIND_LOAD, IDX_W'(MAX_DEGREE_DEF + 1), 32'h1234_5678, PT_W'($urandom));
    push_item(KIND_LOAD, '1, '0, PT_W'($urandom));
    push_item(KIND_EVAL, IDX_W'($urandom), $urandom, '0);
    push_item(KIND_EVAL, IDX_W'($urandom), $urandom, PT_W'(ONE_Q16));
    push_item(KIND_EVAL, IDX_W'($urandom), $urandom, PT_W'(ROUND_HALF));
    push_item(KIND_EVAL, IDX_W'($urandom), $urandom, '1);
    push_item(KIND_EVAL, IDX_W'($urandom), $urandom, PT_W'(1));
    wait_drained();

    foreach (phase_deg[p]) begin
      write_degree(DEG_W'(phase_deg[p]));
      // high degrees are slow, keep those phases short
      n_items = (phase_deg[p] >= MAX_DEGREE_DEF) ? 60 : 132;
      repeat (n_items) random_item();
      wait_drained();
    end

    if (mismatches == 0 && evals_pending == 0) begin
      $display("ALL CHECKS PASSED");
    end else begin
      $display("CHECKS FAILED");
    end
    $finish;
  end

  initial begin : watchdog
    #100_000_000;
    $display("CHECKS FAILED");
    $finish;
  end

endmodule
